### rtl/rsst_pkg.sv
// Shared constants of the range-sum segment tree: payload widths and operation codes.
`default_nettype none

package rsst_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 32;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_RAISE = 2'd2;

endpackage

`default_nettype wire

### rtl/rsst_req_if.sv
// Request channel of the segment tree: valid/ready handshake with the request payload.
`default_nettype none

interface rsst_req_if #(
  parameter int IDX_W = 7
);
  import rsst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         index;
  logic [IDX_W:0]           range_end;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, index, range_end, value, input ready);
  modport sink   (input valid, op, index, range_end, value, output ready);
endinterface

`default_nettype wire

### rtl/rsst_res_if.sv
// Result channel of the segment tree: valid/ready handshake with the query sum.
`default_nettype none

interface rsst_res_if;
  import rsst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

`default_nettype wire

### rtl/rsst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/range_sum_segment_tree.sv
// Top level: sum segment tree over LEAVES leaves held in one node RAM.
//
//   channel  dir  payload                          note
//   req      in   op, index, range_end, value      write / query / raise-to-max
//   res      out  sum                              one per query, none otherwise
//
// A write, or a raise that changes its leaf, runs one leaf read, one compare and leaf
// write, then one step per tree level (sibling read overlaps parent write).
// A raise that keeps its leaf ends after the compare.
// In a query the single RAM read port serves the left and right boundary nodes
// of each level in turn.
// Each request is taken in the idle state.
// After reset the node RAM is cleared, one entry a cycle, over all 2*LEAVES entries;
// req.ready stays low meanwhile. LEAVES must be a power of two.
// A finished query waits in its state while the result register is full and not being taken.
`default_nettype none

module range_sum_segment_tree #(
  parameter int LEAVES = 128
) (
  input wire logic   clk,
  input wire logic   rst,
  rsst_req_if.sink   req,
  rsst_res_if.source res
);
  import rsst_pkg::*;

  localparam int IDX_W = $clog2(LEAVES);
  localparam int AW    = IDX_W + 1;      // node address
  localparam int QW    = IDX_W + 2;      // query bounds reach 2*LEAVES
  localparam int DEPTH = 2 * LEAVES;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LEAF = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UP   = 3'd4;
  localparam logic [2:0] ST_QLO  = 3'd5;
  localparam logic [2:0] ST_QHI  = 3'd6;
  localparam logic [2:0] ST_QOUT = 3'd7;

  localparam logic [IDX_W:0] LEAF_CNT = (IDX_W+1)'(LEAVES);

  logic [2:0]        state;
  logic [OP_W-1:0]   op_q;
  logic [AW-1:0]     node;
  logic [DATA_W-1:0] cur;
  logic [QW-1:0]     lo;
  logic [QW-1:0]     hi;
  logic [DATA_W-1:0] acc;
  logic              pend;
  logic [AW-1:0]     clr_addr;
  logic              res_valid;
  logic [DATA_W-1:0] res_sum;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [DATA_W-1:0] acc_in;
  logic [DATA_W-1:0] up_sum;
  logic [AW-1:0]     parent;
  logic              do_wr;
  logic [IDX_W:0]    end_sat;
  logic [QW-1:0]     hi_dec;
  logic              req_fire;
  logic              res_free;

  rsst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and shared datapath terms
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign res.valid = res_valid;
  assign res.sum   = res_sum;
  assign res_free  = !res_valid || res.ready;

  assign acc_in  = pend ? acc + rd_data : acc;
  assign up_sum  = cur + rd_data;
  assign parent  = {1'b0, node[AW-1:1]};
  assign do_wr   = (op_q == OP_WRITE) || ($signed(cur) > $signed(rd_data));
  assign end_sat = (req.range_end > LEAF_CNT) ? LEAF_CNT : req.range_end;
  assign hi_dec  = hi - QW'(1);

  // RAM port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = node;
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = cur;
    case (state)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_LEAF: begin
        rd_en = 1'b1;
      end
      ST_CMP: begin
        wr_en   = do_wr;
        rd_en   = do_wr;
        rd_addr = node ^ AW'(1);
      end
      ST_UP: begin
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = up_sum;
        rd_en   = (parent != AW'(1));
        rd_addr = parent ^ AW'(1);
      end
      ST_QLO: begin
        rd_en   = (lo < hi) && lo[0];
        rd_addr = lo[AW-1:0];
      end
      ST_QHI: begin
        rd_en   = hi[0];
        rd_addr = hi_dec[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // a query finishing now refills the result register itself
      if (res.valid && res.ready && (state != ST_QOUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            op_q <= req.op;
            node <= AW'(LEAVES) + AW'(req.index);
            cur  <= req.value;
            lo   <= QW'(LEAVES) + QW'(req.index);
            hi   <= QW'(LEAVES) + QW'(end_sat);
            acc  <= '0;
            pend <= 1'b0;
            case (req.op)
              OP_WRITE: state <= ST_LEAF;
              OP_RAISE: state <= ST_LEAF;
              OP_QUERY: state <= ST_QLO;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_LEAF: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= do_wr ? ST_UP : ST_IDLE;
        end
        ST_UP: begin
          node <= parent;
          cur  <= up_sum;
          if (parent == AW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_QLO: begin
          acc  <= acc_in;
          pend <= (lo < hi) && lo[0];
          if (lo < hi) begin
            if (lo[0]) begin
              lo <= lo + QW'(1);
            end
            state <= ST_QHI;
          end else begin
            state <= ST_QOUT;
          end
        end
        ST_QHI: begin
          acc   <= acc_in;
          pend  <= hi[0];
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= ST_QLO;
        end
        ST_QOUT: begin
          if (res_free) begin
            res_valid <= 1'b1;
            res_sum   <= acc;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A write never lands on the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("node RAM read and write hit the same entry");

  // The upward walk never goes past the root
  a_up_below_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP) |-> (node > AW'(1)))
    else $error("tree walk above root");

  // A pending accumulate always follows a RAM read
  a_pend_after_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(rd_en))
    else $error("accumulate without a preceding read");

  // Query bounds stay ordered inside the level loop
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QHI) |-> (lo <= hi))
    else $error("query bounds crossed");

endmodule

`default_nettype wire
